FILE: rtl/gae_pkg.sv
// gae_pkg: shared types, constants and fixed-point helpers of the advantage accumulator
// no dependencies; used by the channel interfaces and gae_advantage_accumulator

package gae_pkg;

  localparam int unsigned MAX_STEPS_DEF = 256;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ENTRY_W       = 2 * DATA_W;
  localparam int unsigned FACTOR_W      = 17;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned ENTRY_COUNT_W = 9;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [FACTOR_W-1:0] ONE_Q16      = 17'd65536;
  localparam logic [FACTOR_W-1:0] DISCOUNT_RST = 17'd64880;
  localparam logic [FACTOR_W-1:0] TRACE_RST    = 17'd62259;

  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_DECAY = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FIRST = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_WALK,
    S_RDWAIT,
    S_FINISH
  } state_e;

  // saturate a 34-bit signed sum to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
    if (v[DATA_W+1:DATA_W-1] == 3'b000 || v[DATA_W+1:DATA_W-1] == 3'b111) begin
      return v[DATA_W-1:0];
    end else if (v[DATA_W+1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  // floor(v * f / 2^16) for a q8.24 value and a q1.16 factor no larger than one
  function automatic logic signed [DATA_W-1:0] scale(input logic signed [DATA_W-1:0] v,
                                                      input logic [FACTOR_W-1:0] f);
    logic signed [49:0] p;
    p = 50'(v) * 50'($signed({1'b0, f}));
    return p[47:16];
  endfunction

  // q1.16 factor product, truncated
  function automatic logic [FACTOR_W-1:0] fmul(input logic [FACTOR_W-1:0] a,
                                               input logic [FACTOR_W-1:0] b);
    logic [2*FACTOR_W-1:0] p;
    p = (2*FACTOR_W)'(a) * (2*FACTOR_W)'(b);
    return p[32:16];
  endfunction

  function automatic logic [FACTOR_W-1:0] clamp_q16(input logic [FACTOR_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

FILE: rtl/gae_req_if.sv
// gae_req_if: request channel of the advantage accumulator (valid/ready plus item fields)
// depends on gae_pkg for field widths

interface gae_req_if
  import gae_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [DATA_W-1:0] state_value;
  logic signed [DATA_W-1:0] reward;
  logic [IDX_W-1:0]         entry_index;

  modport source (output valid, opcode, state_value, reward, entry_index, input ready);
  modport sink   (input valid, opcode, state_value, reward, entry_index, output ready);
endinterface

FILE: rtl/gae_rsp_if.sv
// gae_rsp_if: response channel of the advantage accumulator (valid/ready plus result fields)
// depends on gae_pkg for field widths

interface gae_rsp_if
  import gae_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] td_error;
  logic signed [DATA_W-1:0] advantage;
  logic signed [DATA_W-1:0] return_sum;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, status, td_error, advantage, return_sum, entry_count,
                  input ready);
  modport sink   (input valid, status, td_error, advantage, return_sum, entry_count,
                  output ready);
endinterface

FILE: rtl/gae_ram.sv
// gae_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module gae_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/gae_advantage_accumulator.sv
// gae_advantage_accumulator: online generalized advantage estimation over one episode
// depends on gae_pkg, gae_req_if, gae_rsp_if and gae_ram
//
// usage:
//   req_i carries one transaction per item: start episode, step (reward and new critic
//   value) or read entry. rsp_o returns exactly one result transaction per request.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write discount (index 0) and trace_decay (index 1);
//   values above 1.0 are clamped. write them only while the block is idle.
// item sequence:
//   start, no-op, first-value, store-full and out-of-range items go from accept straight
//   to the finish state, which loads the output register; a read of a stored entry first
//   waits for the ram in the read wait state. a step registers the scaled critic value at
//   accept, then forms delta and appends the newest entry, then does a read-modify-write
//   of each older entry through the single ram read port, then loads the output
//   register.
//   one item is in flight at a time; req_i.ready is high only while idle, so the next
//   request is not taken before the previous result is loaded.
// reset:
//   factors return to their defaults, no first value is held and the store is empty.
//   ram contents are not cleared; entries are always written before they can be read.
// backpressure:
//   the result sits in an output register, so the next request is taken while it
//   waits; a finished result stalls in the finish state until the register frees up.

module gae_advantage_accumulator
  import gae_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FACTOR_W-1:0]  cfg_wdata_i,
  gae_req_if.sink              req_i,
  gae_rsp_if.source            rsp_o
);

  localparam int unsigned AW = $clog2(MAX_STEPS);
  localparam int unsigned CW = $clog2(MAX_STEPS + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  // control state
  state_e               state_q, state_d;
  logic [FACTOR_W-1:0]  disc_q, trace_q;
  logic signed [DATA_W-1:0] prev_q, prev_d;
  logic                 has_q, has_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q, out_valid_d;

  // item payload and walk datapath
  logic signed [DATA_W-1:0] vnew_q, vnew_d;
  logic signed [DATA_W-1:0] rwd_q, rwd_d;
  logic signed [DATA_W-1:0] sv_q, sv_d;        // gamma * vnew
  logic [FACTOR_W-1:0]      lg_q, lg_d;        // lambda * gamma
  logic signed [DATA_W-1:0] delta_q, delta_d;
  logic [FACTOR_W-1:0]      fg_q, fg_d;        // gamma^k
  logic [FACTOR_W-1:0]      fl_q, fl_d;        // (lambda*gamma)^k
  logic [AW-1:0]            addr_q, addr_d;

  // pending result and output register
  status_e                  res_status_q, res_status_d;
  logic signed [DATA_W-1:0] res_td_q, res_td_d;
  logic signed [DATA_W-1:0] res_adv_q, res_adv_d;
  logic signed [DATA_W-1:0] res_ret_q, res_ret_d;
  status_e                  out_status_q, out_status_d;
  logic signed [DATA_W-1:0] out_td_q, out_td_d;
  logic signed [DATA_W-1:0] out_adv_q, out_adv_d;
  logic signed [DATA_W-1:0] out_ret_q, out_ret_d;
  logic [ENTRY_COUNT_W-1:0] out_count_q, out_count_d;

  // ram port signals
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic signed [DATA_W-1:0] rd_adv, rd_ret;
  logic [XW-1:0]            idx_x, cnt_x;

  assign rd_adv = ram_rdata[ENTRY_W-1:DATA_W];
  assign rd_ret = ram_rdata[DATA_W-1:0];
  assign idx_x  = XW'(req_i.entry_index);
  assign cnt_x  = XW'(count_q);

  // entry store: advantage in the upper half, return in the lower half
  gae_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STEPS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.td_error    = out_td_q;
  assign rsp_o.advantage   = out_adv_q;
  assign rsp_o.return_sum  = out_ret_q;
  assign rsp_o.entry_count = out_count_q;

  always_comb begin
    state_d      = state_q;
    prev_d       = prev_q;
    has_d        = has_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    vnew_d       = vnew_q;
    rwd_d        = rwd_q;
    sv_d         = sv_q;
    lg_d         = lg_q;
    delta_d      = delta_q;
    fg_d         = fg_q;
    fl_d         = fl_q;
    addr_d       = addr_q;
    res_status_d = res_status_q;
    res_td_d     = res_td_q;
    res_adv_d    = res_adv_q;
    res_ret_d    = res_ret_q;
    out_status_d = out_status_q;
    out_td_d     = out_td_q;
    out_adv_d    = out_adv_q;
    out_ret_d    = out_ret_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    // result register frees up when the receiver takes it
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          vnew_d       = req_i.state_value;
          rwd_d        = req_i.reward;
          sv_d         = scale(req_i.state_value, disc_q);
          lg_d         = fmul(trace_q, disc_q);
          res_status_d = STAT_OK;
          res_td_d     = '0;
          res_adv_d    = '0;
          res_ret_d    = '0;
          state_d      = S_FINISH;
          case (op_e'(req_i.opcode))
            OP_START: begin
              prev_d       = req_i.state_value;
              has_d        = 1'b1;
              count_d      = '0;
              res_status_d = STAT_FIRST;
            end
            OP_STEP: begin
              if (!has_q) begin
                // first value of the episode only
                prev_d       = req_i.state_value;
                has_d        = 1'b1;
                res_status_d = STAT_FIRST;
              end else if (count_q == CW'(MAX_STEPS)) begin
                res_status_d = STAT_FULL;
              end else begin
                state_d = S_DELTA;
              end
            end
            OP_READ: begin
              if (idx_x < cnt_x) begin
                ram_re    = 1'b1;
                ram_raddr = idx_x[AW-1:0];
                state_d   = S_RDWAIT;
              end else begin
                res_status_d = STAT_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DELTA: begin
        // delta = r + gamma*vnew - vold; newest entry starts at (delta, r)
        delta_d   = sat32((DATA_W+2)'(rwd_q) + (DATA_W+2)'(sv_q) - (DATA_W+2)'(prev_q));
        res_td_d  = delta_d;
        ram_we    = 1'b1;
        ram_waddr = count_q[AW-1:0];
        ram_wdata = {delta_d, rwd_q};
        prev_d    = vnew_q;
        count_d   = count_q + CW'(1);
        fg_d      = disc_q;
        fl_d      = lg_q;
        if (count_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(count_q - CW'(1));
          addr_d    = AW'(count_q - CW'(1));
          state_d   = S_WALK;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_WALK: begin
        // rdata holds entry addr_q; next older entry is read while this one is written
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = {sat32((DATA_W+2)'(rd_adv) + (DATA_W+2)'(scale(delta_q, fl_q))),
                     sat32((DATA_W+2)'(rd_ret) + (DATA_W+2)'(scale(rwd_q, fg_q)))};
        fg_d      = fmul(fg_q, disc_q);
        fl_d      = fmul(fl_q, lg_q);
        if (addr_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = addr_q - AW'(1);
          addr_d    = addr_q - AW'(1);
        end else begin
          state_d = S_FINISH;
        end
      end

      S_RDWAIT: begin
        res_adv_d = rd_adv;
        res_ret_d = rd_ret;
        state_d   = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_td_d     = res_td_q;
          out_adv_d    = res_adv_q;
          out_ret_d    = res_ret_q;
          out_count_d  = ENTRY_COUNT_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q      <= DISCOUNT_RST;
      trace_q     <= TRACE_RST;
      prev_q      <= '0;
      has_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      has_q       <= has_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DISCOUNT:    disc_q  <= clamp_q16(cfg_wdata_i);
          CFG_TRACE_DECAY: trace_q <= clamp_q16(cfg_wdata_i);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vnew_q       <= vnew_d;
    rwd_q        <= rwd_d;
    sv_q         <= sv_d;
    lg_q         <= lg_d;
    delta_q      <= delta_d;
    fg_q         <= fg_d;
    fl_q         <= fl_d;
    addr_q       <= addr_d;
    res_status_q <= res_status_d;
    res_td_q     <= res_td_d;
    res_adv_q    <= res_adv_d;
    res_ret_q    <= res_ret_d;
    out_status_q <= out_status_d;
    out_td_q     <= out_td_d;
    out_adv_q    <= out_adv_d;
    out_ret_q    <= out_ret_d;
    out_count_q  <= out_count_d;
  end

`ifndef SYNTHESIS
  // fill level never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_STEPS))
    else $error("entry count above store depth");

  // the walk never reads the entry it writes in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write collide on one entry");

  // appending an entry grows the count by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DELTA) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("append did not bump entry count");

  // decay factors stay within one during the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (fg_q <= ONE_Q16 && fl_q <= ONE_Q16))
    else $error("decay factor above one");

  // a result is only loaded when the output register is free or being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> out_valid_q)
    else $error("pending result dropped");
`endif

endmodule
